/* rtl/core/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the RTL of the segment frame rotation core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr: assertion failed");

`endif

/* rtl/core/sfr_pkg.sv */
// ============================================================================
// sfr_pkg
// Constants, register indexes and pipeline record types of the segment
// frame rotation core.
// ============================================================================
package sfr_pkg;

    localparam int PT_W      = 32;
    localparam int MIN_LEN_W = 16;
    localparam int MARGIN_W  = 31;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 31;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_MARGIN = 1'b1;

    localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST = 16'd0;
    localparam logic [MARGIN_W-1:0]  COS_MARGIN_RST = 31'd1;

    localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;

    // Width of the normalized delta, steps of the square root and quotient widths of the two dividers.
    localparam int MN_W     = 31;
    localparam int SQ_STEPS = 32;
    localparam int QA_W     = 31;
    localparam int QB_W     = 32;

    typedef struct packed {
        logic [2:0][31:0]     tr;
        logic                 short_seg;
        logic [2:0]           ng;
        logic [2:0][MN_W-1:0] mn;
    } sa_t;

    typedef struct packed {
        logic [2:0][31:0] tr;
        logic             short_seg;
        logic [2:0]       ng;
    } sb_t;

    typedef struct packed {
        logic [2:0][31:0] tr;
        logic             short_seg;
        logic             anti;
        logic             par;
        logic             neg01;
        logic [31:0]      ux;
        logic [31:0]      uy;
        logic [31:0]      c;
    } sc_t;

    // Position of the leading one; zero for a zero input.
    function automatic logic [4:0] lead_pos(input logic [30:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/core/sfr_div.sv */
// ============================================================================
// sfr_div
// Pipelined unsigned divider, one quotient bit per stage, rounding half up
// and saturating the quotient to all ones when it does not fit.
// ============================================================================
module sfr_div #(
    parameter int NW = 62,
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          ce,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int XW = (NW + 1 > QW + DW) ? NW + 1 : QW + DW;

    logic [XW-1:0] nx;
    logic          sat_in;

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW-1];
    logic          sat_reg [0:QW];

    // Adding half the divisor up front turns the truncating division into
    // a rounding one.
    assign nx     = XW'(num) + XW'(den >> 1);
    assign sat_in = nx[XW-1:QW] >= (XW-QW)'(den);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= nx[QW+DW-1:QW];
            low_reg[0] <= nx[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            sat_reg[0] <= sat_in;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        logic [DW:0] t;
        logic        ge;

        assign t  = {rem_reg[j-1], low_reg[j-1][QW-1]};
        assign ge = t >= {1'b0, den_reg[j-1]};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[j] <= ge ? DW'(t - {1'b0, den_reg[j-1]}) : t[DW-1:0];
                quo_reg[j] <= {quo_reg[j-1][QW-2:0], ge};
                sat_reg[j] <= sat_reg[j-1];
            end
        end

        if (j < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    low_reg[j] <= low_reg[j-1] << 1;
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign quo = sat_reg[QW] ? '1 : quo_reg[QW];

endmodule

/* rtl/core/segment_frame_rotation_core.sv */
// ============================================================================
// segment_frame_rotation_core
// Frame carrying +Z onto a segment: midpoint translation (start point for a
// short segment) and Rodrigues rotation in Q1.30.
// ============================================================================
// The core takes one segment request per clock unless a result waits at the
// output; requests are independent and overlap in the pipeline. Its depth
// is set by the 32-step square root and the two banks of bit-per-stage
// dividers (32 and 33 stages). The whole pipeline holds while a result waits
// and m_axis_tready is low, so s_axis_tready is low just then. Configuration
// is written while the core is idle; the core itself does not enforce this.
module segment_frame_rotation_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (lowest bits first)
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mid_x, mid_y, mid_z, rot_00 .. rot_22 row major (lowest bits first)
    output logic [383:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]     cfg_data
);

    `include "assert_macros.svh"

    localparam int LAT = 6 + sfr_pkg::SQ_STEPS + (sfr_pkg::QA_W + 1) + 2
                       + (sfr_pkg::QB_W + 1) + 1;

    logic ce;
    logic acc;
    logic [LAT-1:0] vld_reg;

    logic [sfr_pkg::MIN_LEN_W-1:0] min_length_reg;
    logic [sfr_pkg::MARGIN_W-1:0]  cos_margin_reg;

    assign ce            = m_axis_tready || !vld_reg[LAT-1];
    assign acc           = s_axis_tvalid && ce;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            min_length_reg <= sfr_pkg::MIN_LENGTH_RST;
            cos_margin_reg <= sfr_pkg::COS_MARGIN_RST;
        end
        else
        begin
            if (ce)
            begin
                vld_reg <= {vld_reg[LAT-2:0], acc};
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    sfr_pkg::CFG_MIN_LENGTH: min_length_reg <= cfg_data[15:0];
                    sfr_pkg::CFG_COS_MARGIN: cos_margin_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------- stage 1: delta magnitudes and midpoint ----------------
    logic [2:0][32:0] m1_next, m1_reg;
    logic [2:0]       ng1_next, ng1_reg;
    logic [2:0][31:0] mid1_next, mid1_reg, st1_reg;

    always_comb
    begin
        logic [31:0] s;
        logic [31:0] e;
        logic [32:0] d;
        logic [32:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            s            = s_axis_tdata[32*i +: 32];
            e            = s_axis_tdata[32*(i+3) +: 32];
            d            = {e[31], e} - {s[31], s};
            sum          = {s[31], s} + {e[31], e};
            m1_next[i]   = d[32] ? 33'(33'd0 - d) : d;
            ng1_next[i]  = d[32];
            mid1_next[i] = sum[32:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m1_reg   <= m1_next;
            ng1_reg  <= ng1_next;
            mid1_reg <= mid1_next;
            for (int i = 0; i < 3; i++)
            begin
                st1_reg[i] <= s_axis_tdata[32*i +: 32];
            end
        end
    end

    // ---------------- stage 2: short-segment squares, maximum ---------------
    logic [2:0][31:0] sq2_next, sq2_reg;
    logic [31:0]      minsq2_reg;
    logic             small2_reg;
    logic [32:0]      mx2_next, mx2_reg;
    logic [2:0][32:0] m2_reg;
    logic [2:0]       ng2_reg;
    logic [2:0][31:0] mid2_reg, st2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_next[i] = m1_reg[i][15:0] * m1_reg[i][15:0];
        end
        mx2_next = m1_reg[0];
        if (m1_reg[1] > mx2_next)
        begin
            mx2_next = m1_reg[1];
        end
        if (m1_reg[2] > mx2_next)
        begin
            mx2_next = m1_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq2_reg    <= sq2_next;
            minsq2_reg <= min_length_reg * min_length_reg;
            small2_reg <= (m1_reg[0][32:16] == '0) && (m1_reg[1][32:16] == '0)
                          && (m1_reg[2][32:16] == '0);
            mx2_reg    <= mx2_next;
            m2_reg     <= m1_reg;
            ng2_reg    <= ng1_reg;
            mid2_reg   <= mid1_reg;
            st2_reg    <= st1_reg;
        end
    end

    // ---------------- stage 3: length test and shift amount -----------------
    logic [33:0]      sumsq3;
    logic             short3_next, short3_reg;
    logic [1:0]       rsh3_next, rsh3_reg;
    logic [4:0]       lsh3_next, lsh3_reg;
    logic [2:0][32:0] m3_reg;
    logic [2:0]       ng3_reg;
    logic [2:0][31:0] tr3_reg;

    assign sumsq3 = 34'(sq2_reg[0]) + 34'(sq2_reg[1]) + 34'(sq2_reg[2]);
    assign short3_next = small2_reg && (sumsq3 <= 34'(minsq2_reg));

    always_comb
    begin
        if (mx2_reg[32])
        begin
            rsh3_next = 2'd2;
            lsh3_next = 5'd0;
        end
        else if (mx2_reg[31])
        begin
            rsh3_next = 2'd1;
            lsh3_next = 5'd0;
        end
        else
        begin
            rsh3_next = 2'd0;
            lsh3_next = 5'd30 - sfr_pkg::lead_pos(mx2_reg[30:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            short3_reg <= short3_next;
            rsh3_reg   <= rsh3_next;
            lsh3_reg   <= lsh3_next;
            m3_reg     <= m2_reg;
            ng3_reg    <= ng2_reg;
            tr3_reg    <= short3_next ? st2_reg : mid2_reg;
        end
    end

    // ---------------- stage 4: normalize; stage 5: squares ------------------
    sfr_pkg::sa_t sa4_next, sa4_reg, sa5_reg;
    logic [2:0][61:0] sqm5_reg;

    always_comb
    begin
        logic [32:0] t;
        sa4_next.tr        = tr3_reg;
        sa4_next.short_seg = short3_reg;
        sa4_next.ng        = ng3_reg;
        for (int i = 0; i < 3; i++)
        begin
            t              = (m3_reg[i] >> rsh3_reg) << lsh3_reg;
            sa4_next.mn[i] = t[sfr_pkg::MN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sa4_reg <= sa4_next;
            sa5_reg <= sa4_reg;
            for (int i = 0; i < 3; i++)
            begin
                sqm5_reg[i] <= 62'(sa4_reg.mn[i]) * 62'(sa4_reg.mn[i]);
            end
        end
    end

    // ---------------- stage 6 and square root, one bit per stage ------------
    logic [63:0]  sq_rem_reg  [0:sfr_pkg::SQ_STEPS];
    logic [31:0]  sq_root_reg [0:sfr_pkg::SQ_STEPS];
    sfr_pkg::sa_t sq_sa_reg   [0:sfr_pkg::SQ_STEPS];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq_rem_reg[0]  <= 64'(sqm5_reg[0]) + 64'(sqm5_reg[1]) + 64'(sqm5_reg[2]);
            sq_root_reg[0] <= '0;
            sq_sa_reg[0]   <= sa5_reg;
        end
    end

    for (genvar j = 1; j <= sfr_pkg::SQ_STEPS; j++)
    begin : g_sqrt
        localparam int B = sfr_pkg::SQ_STEPS - j;
        logic [65:0] trial;
        logic        ge;

        assign trial = ({34'd0, sq_root_reg[j-1]} << (B + 1)) + (66'd1 << (2 * B));
        assign ge    = {2'b00, sq_rem_reg[j-1]} >= trial;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                sq_rem_reg[j]  <= ge ? sq_rem_reg[j-1] - trial[63:0] : sq_rem_reg[j-1];
                sq_root_reg[j] <= ge ? (sq_root_reg[j-1] | (32'd1 << B))
                                     : sq_root_reg[j-1];
                sq_sa_reg[j]   <= sq_sa_reg[j-1];
            end
        end
    end

    // ---------------- unit vector: (m << 30) / length -----------------------
    logic [2:0][sfr_pkg::QA_W-1:0] qa;
    sfr_pkg::sb_t sb_reg [0:sfr_pkg::QA_W];

    for (genvar i = 0; i < 3; i++)
    begin : g_diva
        sfr_div #(
            .NW (sfr_pkg::MN_W + 30),
            .DW (32),
            .QW (sfr_pkg::QA_W)
        ) u_div (
            .clk (clk),
            .ce  (ce),
            .num ({sq_sa_reg[sfr_pkg::SQ_STEPS].mn[i], 30'd0}),
            .den (sq_root_reg[sfr_pkg::SQ_STEPS]),
            .quo (qa[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sb_reg[0].tr        <= sq_sa_reg[sfr_pkg::SQ_STEPS].tr;
            sb_reg[0].short_seg <= sq_sa_reg[sfr_pkg::SQ_STEPS].short_seg;
            sb_reg[0].ng        <= sq_sa_reg[sfr_pkg::SQ_STEPS].ng;
            for (int k = 1; k <= sfr_pkg::QA_W; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // ---------------- case tests; then products for the second divide -------
    localparam logic [31:0] ONE_Q30_U = 32'h4000_0000;

    sfr_pkg::sc_t sc_p_next, sc_p_reg, sc_x_reg;
    logic [31:0]  q_p_next, q_p_reg, q_x_reg;
    logic [sfr_pkg::QA_W-1:0] ax_p_reg, ay_p_reg;
    logic [61:0]  pxx_reg, pyy_reg, pxy_reg;

    always_comb
    begin
        sfr_pkg::sb_t sb;
        sb = sb_reg[sfr_pkg::QA_W];
        sc_p_next.tr        = sb.tr;
        sc_p_next.short_seg = sb.short_seg;
        sc_p_next.ux = sb.ng[0] ? 32'd0 - 32'(qa[0]) : 32'(qa[0]);
        sc_p_next.uy = sb.ng[1] ? 32'd0 - 32'(qa[1]) : 32'(qa[1]);
        sc_p_next.c  = sb.ng[2] ? 32'd0 - 32'(qa[2]) : 32'(qa[2]);
        // q = 1 + c in Q1.30 is never negative, so both cosine tests are
        // made on it unsigned.
        q_p_next = sc_p_next.c + 32'(ONE_Q30_U);
        sc_p_next.anti  = (q_p_next < 32'(cos_margin_reg)) || (q_p_next == 32'd0);
        sc_p_next.par   = (33'(q_p_next) + 33'(cos_margin_reg)) >= 33'h0_8000_0000;
        sc_p_next.neg01 = sc_p_next.ux[31] == sc_p_next.uy[31];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sc_p_reg <= sc_p_next;
            q_p_reg  <= q_p_next;
            ax_p_reg <= qa[0];
            ay_p_reg <= qa[1];
            sc_x_reg <= sc_p_reg;
            q_x_reg  <= q_p_reg;
            pxx_reg  <= 62'(ax_p_reg) * 62'(ax_p_reg);
            pyy_reg  <= 62'(ay_p_reg) * 62'(ay_p_reg);
            pxy_reg  <= 62'(ax_p_reg) * 62'(ay_p_reg);
        end
    end

    // ---------------- second divide by q ------------------------------------
    logic [sfr_pkg::QB_W-1:0] qb_xx, qb_yy, qb_xy;
    sfr_pkg::sc_t sc_reg [0:sfr_pkg::QB_W];

    sfr_div #(.NW(62), .DW(32), .QW(sfr_pkg::QB_W)) u_div_xx (
        .clk (clk), .ce (ce), .num (pxx_reg), .den (q_x_reg), .quo (qb_xx)
    );
    sfr_div #(.NW(62), .DW(32), .QW(sfr_pkg::QB_W)) u_div_yy (
        .clk (clk), .ce (ce), .num (pyy_reg), .den (q_x_reg), .quo (qb_yy)
    );
    sfr_div #(.NW(62), .DW(32), .QW(sfr_pkg::QB_W)) u_div_xy (
        .clk (clk), .ce (ce), .num (pxy_reg), .den (q_x_reg), .quo (qb_xy)
    );

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sc_reg[0] <= sc_x_reg;
            for (int k = 1; k <= sfr_pkg::QB_W; k++)
            begin
                sc_reg[k] <= sc_reg[k-1];
            end
        end
    end

    // ---------------- output: clamp and select the case ---------------------
    function automatic logic [31:0] clamp_diag(input logic [31:0] qv);
        return (qv > 32'h8000_0000) ? 32'(sfr_pkg::NEG_ONE_Q30) : ONE_Q30_U - qv;
    endfunction

    function automatic logic [31:0] clamp_off(input logic [31:0] qv, input logic neg);
        logic [31:0] mag;
        mag = (qv > ONE_Q30_U) ? ONE_Q30_U : qv;
        return neg ? 32'd0 - mag : mag;
    endfunction

    function automatic logic rot_in_range(input logic [31:0] v);
        return ($signed(v) <= sfr_pkg::ONE_Q30) && ($signed(v) >= sfr_pkg::NEG_ONE_Q30);
    endfunction

    logic [2:0][31:0]        out_tr_next, out_tr_reg;
    logic signed [8:0][31:0] out_rot_next, out_rot_reg;

    always_comb
    begin
        sfr_pkg::sc_t sc;
        logic [31:0] r01;
        sc          = sc_reg[sfr_pkg::QB_W];
        r01         = clamp_off(qb_xy, sc.neg01);
        out_tr_next = sc.tr;
        out_rot_next = '0;
        out_rot_next[0] = sfr_pkg::ONE_Q30;
        out_rot_next[4] = sfr_pkg::ONE_Q30;
        out_rot_next[8] = sfr_pkg::ONE_Q30;
        if (sc.short_seg)
        begin
            out_rot_next[0] = sfr_pkg::ONE_Q30;
        end
        else if (sc.anti)
        begin
            out_rot_next[4] = sfr_pkg::NEG_ONE_Q30;
            out_rot_next[8] = sfr_pkg::NEG_ONE_Q30;
        end
        else if (!sc.par)
        begin
            out_rot_next[0] = clamp_diag(qb_xx);
            out_rot_next[1] = r01;
            out_rot_next[2] = sc.ux;
            out_rot_next[3] = r01;
            out_rot_next[4] = clamp_diag(qb_yy);
            out_rot_next[5] = sc.uy;
            out_rot_next[6] = 32'd0 - sc.ux;
            out_rot_next[7] = 32'd0 - sc.uy;
            out_rot_next[8] = sc.c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_tr_reg  <= out_tr_next;
            out_rot_reg <= out_rot_next;
        end
    end

    assign m_axis_tdata = {out_rot_reg, out_tr_reg};

    // ---------------- assertions --------------------------------------------
    `SFR_ASSERT_NEXT(a_hold_on_stall, !ce, $stable(vld_reg))
    `SFR_ASSERT_NOW(a_rot00_range, m_axis_tvalid, rot_in_range(out_rot_reg[0]))
    `SFR_ASSERT_NOW(a_rot11_range, m_axis_tvalid, rot_in_range(out_rot_reg[4]))

endmodule
